[design/srarq_pkg.sv]
// Shared types, widths and codes for the selective-repeat ARQ window controller.
`default_nettype none
package srarq_pkg;

    // Sequence numbers run modulo 32, buffer slots modulo 16
    localparam int SEQ_W       = 5;
    localparam int SLOT_W      = 4;
    localparam int WINDOW_BUFS = 16;
    localparam int CNT_W       = 5;

    // Request codes
    localparam logic [2:0] REQ_NET_READY  = 3'd0;
    localparam logic [2:0] REQ_PHYS_READY = 3'd1;
    localparam logic [2:0] REQ_FRAME      = 3'd2;
    localparam logic [2:0] REQ_ACK_TMO    = 3'd3;
    localparam logic [2:0] REQ_DATA_TMO   = 3'd4;

    // Frame kinds
    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_ACK  = 2'd1;
    localparam logic [1:0] KIND_NAK  = 2'd2;

    // Action codes
    localparam logic [2:0] ACT_TX       = 3'd0;
    localparam logic [2:0] ACT_DELIVER  = 3'd1;
    localparam logic [2:0] ACT_RELEASE  = 3'd2;
    localparam logic [2:0] ACT_ACK_TMR  = 3'd3;
    localparam logic [2:0] ACT_STATUS   = 3'd4;

    // One result beat
    typedef struct packed {
        logic [2:0]        action;
        logic [1:0]        tx_kind;
        logic [SEQ_W-1:0]  tx_seq;
        logic [SEQ_W-1:0]  tx_ack;
        logic [SLOT_W-1:0] slot;
        logic              net_enable;
        logic              last;
    } t_res;

    // Operands of the shared window compare unit
    typedef struct packed {
        logic [SEQ_W-1:0] lo;
        logic [SEQ_W-1:0] val;
        logic [SEQ_W-1:0] hi;
    } t_win_op;

endpackage
`default_nettype wire

[design/srarq_if.sv]
// Event and result channel interfaces of the ARQ window controller.
`default_nettype none
interface srarq_in_if;
    logic                          valid;
    logic                          ready;
    logic [2:0]                    req_type;
    logic                          frame_good;
    logic [1:0]                    frame_kind;
    logic [srarq_pkg::SEQ_W-1:0]   frame_seq;
    logic [srarq_pkg::SEQ_W-1:0]   rx_ack;
    logic [srarq_pkg::SLOT_W-1:0]  timer_slot;

    modport source (output valid, req_type, frame_good, frame_kind, frame_seq, rx_ack,
                    timer_slot, input ready);
    modport sink   (input valid, req_type, frame_good, frame_kind, frame_seq, rx_ack,
                    timer_slot, output ready);
endinterface

interface srarq_out_if;
    logic                          valid;
    logic                          ready;
    logic [2:0]                    action;
    logic [1:0]                    tx_kind;
    logic [srarq_pkg::SEQ_W-1:0]   tx_seq;
    logic [srarq_pkg::SEQ_W-1:0]   tx_ack;
    logic [srarq_pkg::SLOT_W-1:0]  slot;
    logic                          net_enable;
    logic                          last;

    modport source (output valid, action, tx_kind, tx_seq, tx_ack, slot, net_enable, last,
                    input ready);
    modport sink   (input valid, action, tx_kind, tx_seq, tx_ack, slot, net_enable, last,
                    output ready);
endinterface
`default_nettype wire

[design/srarq_win.sv]
// Shared circular-window compare and modulo increment unit.
`default_nettype none
module srarq_win (
    input  wire srarq_pkg::t_win_op   i_op,
    output logic                      o_in_win,
    output logic [srarq_pkg::SEQ_W-1:0] o_lo_inc
);
    import srarq_pkg::*;

    // val in the circular interval [lo, hi)
    assign o_in_win = ((i_op.lo <= i_op.val) && (i_op.val < i_op.hi)) ||
                      ((i_op.hi < i_op.lo) && (i_op.lo <= i_op.val)) ||
                      ((i_op.val < i_op.hi) && (i_op.hi < i_op.lo));

    // Wraps naturally at the sequence modulus
    assign o_lo_inc = i_op.lo + SEQ_W'(1);

endmodule
`default_nettype wire

[design/selective_repeat_arq_control.sv]
// Top level: event sequencer, window state and result register of the ARQ controller.
`default_nettype none
// Selective-repeat ARQ window controller. One event beat is taken on i_req when the
// block is idle; it then emits that event's action beats on o_res, one per cycle while
// o_res is not stalled, always ending with a status beat (last = 1) that carries
// net_enable. A frame that delivers a full window of 16 slots and then releases a full
// send window takes longest: the sequencer walks the arrival bitmap and the send window
// one slot per cycle while o_res is not stalled, through a single shared window-compare
// unit. Stalls on o_res hold the walk. The arrival bitmap is cleared by reset; no
// clearing pass is needed.
module selective_repeat_arq_control (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    srarq_in_if.sink   i_req,
    srarq_out_if.source o_res
);
    import srarq_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE      = 8'b0000_0001,
        S_DISPATCH  = 8'b0000_0010,
        S_DELIVER   = 8'b0000_0100,
        S_ACK_TMR   = 8'b0000_1000,
        S_RETX_CALC = 8'b0001_0000,
        S_RETX      = 8'b0010_0000,
        S_RELEASE   = 8'b0100_0000,
        S_STATUS    = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    // Latched event
    logic [2:0]        r_req_type;
    logic              r_good;
    logic [1:0]        r_kind;
    logic [SEQ_W-1:0]  r_seq;
    logic [SEQ_W-1:0]  r_ack;
    logic [SLOT_W-1:0] r_tslot;

    // Window state
    logic [SEQ_W-1:0]       r_next_to_send, n_next_to_send;
    logic [SEQ_W-1:0]       r_send_base, n_send_base;
    logic [SEQ_W-1:0]       r_recv_base, n_recv_base;
    logic [SEQ_W-1:0]       r_recv_limit, n_recv_limit;
    logic [CNT_W-1:0]       r_buf_cnt, n_buf_cnt;
    logic [WINDOW_BUFS-1:0] r_arrived, n_arrived;
    logic                   r_nak_ok, n_nak_ok;
    logic                   r_phys_rdy, n_phys_rdy;
    logic                   r_any, n_any;
    logic [SEQ_W-1:0]       r_tmp, n_tmp;

    // Result register
    logic r_out_valid, n_out_valid;
    t_res r_res, n_res;

    // Shared unit
    t_win_op          w_op;
    logic             w_in_win;
    logic [SEQ_W-1:0] w_lo_inc;

    srarq_win u_win (
        .i_op     (w_op),
        .o_in_win (w_in_win),
        .o_lo_inc (w_lo_inc)
    );

    logic             w_fire;
    logic [SEQ_W-1:0] w_ack_num;
    logic             w_win_full;

    assign w_fire     = !r_out_valid || o_res.ready;
    assign w_ack_num  = r_recv_base - SEQ_W'(1);
    assign w_win_full = r_buf_cnt >= CNT_W'(WINDOW_BUFS);

    assign i_req.ready      = (r_state == S_IDLE);
    assign o_res.valid      = r_out_valid;
    assign o_res.action     = r_res.action;
    assign o_res.tx_kind    = r_res.tx_kind;
    assign o_res.tx_seq     = r_res.tx_seq;
    assign o_res.tx_ack     = r_res.tx_ack;
    assign o_res.slot       = r_res.slot;
    assign o_res.net_enable = r_res.net_enable;
    assign o_res.last       = r_res.last;

    // Operand select for the shared unit
    always_comb begin
        w_op = '0;
        unique case (r_state)
            S_DISPATCH: begin
                if (r_req_type == REQ_DATA_TMO) begin
                    w_op.lo  = r_send_base;
                    w_op.val = {1'b0, r_tslot};
                    w_op.hi  = r_next_to_send;
                end else begin
                    w_op.lo  = r_recv_base;
                    w_op.val = r_seq;
                    w_op.hi  = r_recv_limit;
                end
            end
            S_DELIVER:   w_op.lo = r_recv_base;
            S_RETX_CALC: w_op.lo = r_ack;
            S_RETX: begin
                w_op.lo  = r_send_base;
                w_op.val = r_tmp;
                w_op.hi  = r_next_to_send;
            end
            S_RELEASE: begin
                w_op.lo  = r_send_base;
                w_op.val = r_ack;
                w_op.hi  = r_next_to_send;
            end
            default: w_op = '0;
        endcase
    end

    // Sequencer
    always_comb begin
        n_state        = r_state;
        n_next_to_send = r_next_to_send;
        n_send_base    = r_send_base;
        n_recv_base    = r_recv_base;
        n_recv_limit   = r_recv_limit;
        n_buf_cnt      = r_buf_cnt;
        n_arrived      = r_arrived;
        n_nak_ok       = r_nak_ok;
        n_phys_rdy     = r_phys_rdy;
        n_any          = r_any;
        n_tmp          = r_tmp;
        n_res          = r_res;
        n_out_valid    = r_out_valid && !o_res.ready;

        if (r_state == S_IDLE) begin
            if (i_req.valid) begin
                n_state = S_DISPATCH;
            end
        end else if (w_fire) begin
            n_res        = '0;
            n_res.tx_ack = w_ack_num;
            unique case (r_state)
                S_DISPATCH: begin
                    n_state = S_STATUS;
                    priority if (r_req_type == REQ_NET_READY) begin
                        if (!w_win_full) begin
                            n_buf_cnt      = r_buf_cnt + CNT_W'(1);
                            n_res.action   = ACT_TX;
                            n_res.tx_kind  = KIND_DATA;
                            n_res.tx_seq   = r_next_to_send;
                            n_res.slot     = r_next_to_send[SLOT_W-1:0];
                            n_out_valid    = 1'b1;
                            n_phys_rdy     = 1'b0;
                            n_next_to_send = r_next_to_send + SEQ_W'(1);
                        end
                    end else if (r_req_type == REQ_PHYS_READY) begin
                        n_phys_rdy = 1'b1;
                    end else if (r_req_type == REQ_FRAME) begin
                        if (!r_good) begin
                            if (r_nak_ok) begin
                                n_res.action  = ACT_TX;
                                n_res.tx_kind = KIND_NAK;
                                n_out_valid   = 1'b1;
                                n_nak_ok      = 1'b0;
                                n_phys_rdy    = 1'b0;
                            end
                        end else if (r_kind == KIND_DATA) begin
                            // NAK on an out-of-order frame while a NAK is allowed, else restart the ack timer
                            if (r_seq != r_recv_base && r_nak_ok) begin
                                n_res.action  = ACT_TX;
                                n_res.tx_kind = KIND_NAK;
                                n_nak_ok      = 1'b0;
                                n_phys_rdy    = 1'b0;
                            end else begin
                                n_res        = '0;
                                n_res.action = ACT_ACK_TMR;
                            end
                            n_out_valid = 1'b1;
                            if (w_in_win && !r_arrived[r_seq[SLOT_W-1:0]]) begin
                                n_arrived[r_seq[SLOT_W-1:0]] = 1'b1;
                                n_any   = 1'b0;
                                n_state = S_DELIVER;
                            end else begin
                                n_state = S_RELEASE;
                            end
                        end else if (r_kind == KIND_NAK) begin
                            n_state = S_RETX_CALC;
                        end else begin
                            n_state = S_RELEASE;
                        end
                    end else if (r_req_type == REQ_ACK_TMO) begin
                        n_res.action  = ACT_TX;
                        n_res.tx_kind = KIND_ACK;
                        n_out_valid   = 1'b1;
                        n_phys_rdy    = 1'b0;
                    end else if (r_req_type == REQ_DATA_TMO) begin
                        // Outside the send window the slot maps to the upper half
                        n_res.action  = ACT_TX;
                        n_res.tx_kind = KIND_DATA;
                        n_res.tx_seq  = {!w_in_win, r_tslot};
                        n_res.slot    = r_tslot;
                        n_out_valid   = 1'b1;
                        n_phys_rdy    = 1'b0;
                    end else begin
                        n_state = S_STATUS;
                    end
                end

                // Walk in-order arrivals, one slot per cycle while o_res is not stalled
                S_DELIVER: begin
                    if (r_arrived[r_recv_base[SLOT_W-1:0]]) begin
                        n_res        = '0;
                        n_res.action = ACT_DELIVER;
                        n_res.slot   = r_recv_base[SLOT_W-1:0];
                        n_out_valid  = 1'b1;
                        n_nak_ok     = 1'b1;
                        n_arrived[r_recv_base[SLOT_W-1:0]] = 1'b0;
                        n_recv_base  = w_lo_inc;
                        n_recv_limit = r_recv_limit + SEQ_W'(1);
                        n_any        = 1'b1;
                    end else begin
                        n_state = r_any ? S_ACK_TMR : S_RELEASE;
                    end
                end

                S_ACK_TMR: begin
                    n_res        = '0;
                    n_res.action = ACT_ACK_TMR;
                    n_out_valid  = 1'b1;
                    n_state      = S_RELEASE;
                end

                S_RETX_CALC: begin
                    n_tmp   = w_lo_inc;
                    n_state = S_RETX;
                end

                // Resend the frame after the one the NAK names, if it lies in the send window
                S_RETX: begin
                    if (w_in_win) begin
                        n_res.action  = ACT_TX;
                        n_res.tx_kind = KIND_DATA;
                        n_res.tx_seq  = r_tmp;
                        n_res.slot    = r_tmp[SLOT_W-1:0];
                        n_out_valid   = 1'b1;
                        n_phys_rdy    = 1'b0;
                    end
                    n_state = S_RELEASE;
                end

                // Free acknowledged send slots, one per cycle while o_res is not stalled
                S_RELEASE: begin
                    if (w_in_win) begin
                        n_res        = '0;
                        n_res.action = ACT_RELEASE;
                        n_res.slot   = r_send_base[SLOT_W-1:0];
                        n_out_valid  = 1'b1;
                        if (r_buf_cnt != '0) begin
                            n_buf_cnt = r_buf_cnt - CNT_W'(1);
                        end
                        n_send_base = w_lo_inc;
                    end else begin
                        n_state = S_STATUS;
                    end
                end

                S_STATUS: begin
                    n_res            = '0;
                    n_res.action     = ACT_STATUS;
                    n_res.net_enable = !w_win_full && r_phys_rdy;
                    n_res.last       = 1'b1;
                    n_out_valid      = 1'b1;
                    n_state          = S_IDLE;
                end

                default: n_state = S_IDLE;
            endcase
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_next_to_send <= '0;
            r_send_base    <= '0;
            r_recv_base    <= '0;
            r_recv_limit   <= SEQ_W'(WINDOW_BUFS);
            r_buf_cnt      <= '0;
            r_arrived      <= '0;
            r_nak_ok       <= 1'b1;
            r_phys_rdy     <= 1'b0;
            r_any          <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_next_to_send <= n_next_to_send;
            r_send_base    <= n_send_base;
            r_recv_base    <= n_recv_base;
            r_recv_limit   <= n_recv_limit;
            r_buf_cnt      <= n_buf_cnt;
            r_arrived      <= n_arrived;
            r_nak_ok       <= n_nak_ok;
            r_phys_rdy     <= n_phys_rdy;
            r_any          <= n_any;
            r_out_valid    <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        r_tmp <= n_tmp;
        if (i_req.valid && i_req.ready) begin
            r_req_type <= i_req.req_type;
            r_good     <= i_req.frame_good;
            r_kind     <= i_req.frame_kind;
            r_seq      <= i_req.frame_seq;
            r_ack      <= i_req.rx_ack;
            r_tslot    <= i_req.timer_slot;
        end
    end

endmodule
`default_nettype wire
